@@ rtl/core/bresenham_line_rasterizer_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the line rasterizer.
// Each macro expands to one labeled concurrent assertion, checked on the
// rising clock edge and switched off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_TOP_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_TOP_ASSERT_SVH

// Condition in the same cycle implies the consequence in the same cycle.
`define BLR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition in one cycle implies the consequence in the next cycle.
`define BLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/blr_pkg.sv @@
// ----------------------------------------------------------------------------
// blr_pkg
// Types and constants shared by the line rasterizer: operation codes,
// configuration register indexes, register widths and reset values.
// ----------------------------------------------------------------------------
package blr_pkg;

    // Operation carried by an input transaction.
    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ADDRESS    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_STRIDE      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BYTES_PER_PIXEL = 3'd4;

    // Field widths.
    localparam int ADDR_W   = 32;
    localparam int COLOUR_W = 32;
    localparam int SIZE_W   = 13;
    localparam int STRIDE_W = 16;
    localparam int BPP_W    = 3;

    // Register reset values.
    localparam logic [ADDR_W-1:0]   BASE_ADDRESS_RST    = 32'd0;
    localparam logic [SIZE_W-1:0]   SCREEN_WIDTH_RST    = 13'd1024;
    localparam logic [SIZE_W-1:0]   SCREEN_HEIGHT_RST   = 13'd768;
    localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST      = 16'd4096;
    localparam logic [BPP_W-1:0]    BYTES_PER_PIXEL_RST = 3'd4;

endpackage

@@ rtl/core/bresenham_line_rasterizer_top.sv @@
// A pixel is registered on the output in the cycle after its advance is accepted.
// Throughput: one input transaction per cycle while in_stall is low; one Bresenham
// step per advance, set by the error-term add and two compares on the line state registers.
// A load produces no pixel; an advance while idle is dropped.
// Reset (rst_n low, asynchronous) idles the line, empties the output register
// and returns the configuration registers to their documented defaults.
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_top
// Integer Bresenham line rasterizer. A load latches two endpoints and a
// colour; each advance on an active line emits one pixel with its framebuffer
// byte address, a visibility flag and a last-pixel flag.
// ----------------------------------------------------------------------------
`include "bresenham_line_rasterizer_top_assert.svh"

module bresenham_line_rasterizer_top #(
    parameter int COORD_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,

    // Configuration write port
    input  logic                               cfg_write_en,
    input  logic [blr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [blr_pkg::CFG_DATA_W-1:0]     cfg_data,

    // Input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  blr_pkg::op_t                       operation,
    input  logic [COORD_BITS-1:0]              start_x,
    input  logic [COORD_BITS-1:0]              start_y,
    input  logic [COORD_BITS-1:0]              finish_x,
    input  logic [COORD_BITS-1:0]              finish_y,
    input  logic [blr_pkg::COLOUR_W-1:0]       colour_word,

    // Output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [COORD_BITS-1:0]              pixel_x,
    output logic [COORD_BITS-1:0]              pixel_y,
    output logic [blr_pkg::ADDR_W-1:0]         byte_address,
    output logic [blr_pkg::COLOUR_W-1:0]       pixel_colour,
    output logic                               visible,
    output logic                               last_pixel
);

    import blr_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int EW    = COORD_BITS + 2;
    localparam int CMP_W = (COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W;

    // Configuration registers
    logic [ADDR_W-1:0]   base_address_reg;
    logic [SIZE_W-1:0]   screen_width_reg;
    logic [SIZE_W-1:0]   screen_height_reg;
    logic [STRIDE_W-1:0] row_stride_reg;
    logic [BPP_W-1:0]    bytes_per_pixel_reg;

    // Line state
    logic                 line_active_reg, line_active_next;
    logic [CW-1:0]        cursor_x_reg, cursor_x_next;
    logic [CW-1:0]        cursor_y_reg, cursor_y_next;
    logic [CW-1:0]        target_x_reg, target_x_next;
    logic [CW-1:0]        target_y_reg, target_y_next;
    logic [CW-1:0]        delta_x_reg, delta_x_next;
    logic signed [CW:0]   neg_delta_y_reg, neg_delta_y_next;
    logic                 step_x_neg_reg, step_x_neg_next;
    logic                 step_y_neg_reg, step_y_neg_next;
    logic signed [EW-1:0] error_reg, error_next;
    logic [COLOUR_W-1:0]  pen_colour_reg, pen_colour_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [CW-1:0]        pixel_x_reg;
    logic [CW-1:0]        pixel_y_reg;
    logic [ADDR_W-1:0]    byte_address_reg;
    logic [COLOUR_W-1:0]  pixel_colour_reg;
    logic                 visible_reg;
    logic                 last_pixel_reg;

    // Datapath signals
    logic                 in_accept;
    logic                 produce;
    logic                 at_target;
    logic [CW-1:0]        load_dx;
    logic [CW-1:0]        load_dy;
    logic signed [CW:0]   load_neg_dy;
    logic signed [EW:0]   error_x2;
    logic                 step_x;
    logic                 step_y;
    logic [CW+STRIDE_W-1:0] row_offset;
    logic [CW+BPP_W-1:0]  col_offset;
    logic [ADDR_W-1:0]    pixel_address;
    logic                 pixel_visible;

    // Handshake: only a full output register that is being held stalls the input.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign produce   = in_accept && (operation == OP_ADVANCE) && line_active_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg    <= BASE_ADDRESS_RST;
            screen_width_reg    <= SCREEN_WIDTH_RST;
            screen_height_reg   <= SCREEN_HEIGHT_RST;
            row_stride_reg      <= ROW_STRIDE_RST;
            bytes_per_pixel_reg <= BYTES_PER_PIXEL_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_BASE_ADDRESS:    base_address_reg    <= cfg_data[ADDR_W-1:0];
                CFG_SCREEN_WIDTH:    screen_width_reg    <= cfg_data[SIZE_W-1:0];
                CFG_SCREEN_HEIGHT:   screen_height_reg   <= cfg_data[SIZE_W-1:0];
                CFG_ROW_STRIDE:      row_stride_reg      <= cfg_data[STRIDE_W-1:0];
                CFG_BYTES_PER_PIXEL: bytes_per_pixel_reg <= cfg_data[BPP_W-1:0];
                default:             ;
            endcase
        end
    end

    // Endpoint distances for a load.
    assign load_dx     = (start_x > finish_x) ? (start_x - finish_x) : (finish_x - start_x);
    assign load_dy     = (start_y > finish_y) ? (start_y - finish_y) : (finish_y - start_y);
    assign load_neg_dy = -$signed({1'b0, load_dy});

    // Bresenham step decisions, both taken from the current error term.
    assign at_target = (cursor_x_reg == target_x_reg) && (cursor_y_reg == target_y_reg);
    assign error_x2  = {error_reg, 1'b0};
    assign step_x    = error_x2 >= (EW+1)'(neg_delta_y_reg);
    assign step_y    = error_x2 <= $signed({3'b000, delta_x_reg});

    // Pixel address and clipping for the current cursor.
    assign row_offset    = cursor_y_reg * row_stride_reg;
    assign col_offset    = cursor_x_reg * bytes_per_pixel_reg;
    assign pixel_address = base_address_reg + ADDR_W'(row_offset) + ADDR_W'(col_offset);
    assign pixel_visible = (CMP_W'(cursor_x_reg) < CMP_W'(screen_width_reg)) &&
                           (CMP_W'(cursor_y_reg) < CMP_W'(screen_height_reg));

    // Next state of the line.
    always_comb
    begin
        line_active_next = line_active_reg;
        cursor_x_next    = cursor_x_reg;
        cursor_y_next    = cursor_y_reg;
        target_x_next    = target_x_reg;
        target_y_next    = target_y_reg;
        delta_x_next     = delta_x_reg;
        neg_delta_y_next = neg_delta_y_reg;
        step_x_neg_next  = step_x_neg_reg;
        step_y_neg_next  = step_y_neg_reg;
        error_next       = error_reg;
        pen_colour_next  = pen_colour_reg;
        out_valid_next   = produce || (out_valid_reg && out_stall);

        if (in_accept)
        begin
            unique case (operation)
                OP_LOAD:
                begin
                    line_active_next = 1'b1;
                    cursor_x_next    = start_x;
                    cursor_y_next    = start_y;
                    target_x_next    = finish_x;
                    target_y_next    = finish_y;
                    delta_x_next     = load_dx;
                    neg_delta_y_next = load_neg_dy;
                    step_x_neg_next  = !(start_x < finish_x);
                    step_y_neg_next  = !(start_y < finish_y);
                    error_next       = $signed({2'b00, load_dx}) + EW'(load_neg_dy);
                    pen_colour_next  = colour_word;
                end
                OP_ADVANCE:
                begin
                    if (line_active_reg)
                    begin
                        if (at_target)
                        begin
                            line_active_next = 1'b0;
                        end
                        else
                        begin
                            error_next = error_reg
                                       + (step_x ? EW'(neg_delta_y_reg) : EW'(0))
                                       + (step_y ? $signed({2'b00, delta_x_reg}) : EW'(0));
                            if (step_x)
                            begin
                                cursor_x_next = step_x_neg_reg ? (cursor_x_reg - 1'b1)
                                                               : (cursor_x_reg + 1'b1);
                            end
                            if (step_y)
                            begin
                                cursor_y_next = step_y_neg_reg ? (cursor_y_reg - 1'b1)
                                                               : (cursor_y_reg + 1'b1);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Line state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg <= 1'b0;
            cursor_x_reg    <= '0;
            cursor_y_reg    <= '0;
            target_x_reg    <= '0;
            target_y_reg    <= '0;
            delta_x_reg     <= '0;
            neg_delta_y_reg <= '0;
            step_x_neg_reg  <= 1'b0;
            step_y_neg_reg  <= 1'b0;
            error_reg       <= '0;
            pen_colour_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            line_active_reg <= line_active_next;
            cursor_x_reg    <= cursor_x_next;
            cursor_y_reg    <= cursor_y_next;
            target_x_reg    <= target_x_next;
            target_y_reg    <= target_y_next;
            delta_x_reg     <= delta_x_next;
            neg_delta_y_reg <= neg_delta_y_next;
            step_x_neg_reg  <= step_x_neg_next;
            step_y_neg_reg  <= step_y_neg_next;
            error_reg       <= error_next;
            pen_colour_reg  <= pen_colour_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result payload, loaded only when a pixel transaction is produced.
    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            pixel_x_reg      <= cursor_x_reg;
            pixel_y_reg      <= cursor_y_reg;
            byte_address_reg <= pixel_address;
            pixel_colour_reg <= pen_colour_reg;
            visible_reg      <= pixel_visible;
            last_pixel_reg   <= at_target;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign byte_address = byte_address_reg;
    assign pixel_colour = pixel_colour_reg;
    assign visible      = visible_reg;
    assign last_pixel   = last_pixel_reg;

    // Checks on the line sequencing and the output register.
    `BLR_ASSERT_SAME(a_stall_needs_full, clk, rst_n, in_stall, out_valid_reg, "input stalled while output register empty")
    `BLR_ASSERT_NEXT(a_pixel_lands, clk, rst_n, produce, out_valid_reg, "produced pixel did not reach the output register")
    `BLR_ASSERT_NEXT(a_load_arms, clk, rst_n, in_accept && (operation == OP_LOAD), line_active_reg, "load did not arm the line")
    `BLR_ASSERT_NEXT(a_last_ends_line, clk, rst_n, produce && at_target, !line_active_reg && last_pixel_reg, "final pixel did not end the line")

endmodule

@@ tb/sv/bresenham_line_rasterizer_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line rasterizer testbench
// Drives load and advance transactions into the rasterizer under random
// sender gaps and receiver stalls. A software line walker predicts every
// pixel, and each accepted pixel is compared field by field against it.
// Configuration is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_top_test;
    import blr_pkg::*;

    localparam int COORD_W     = 12;
    localparam int COORD_MAX   = (1 << COORD_W) - 1;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic [COORD_W-1:0]        coord_t;
    typedef logic signed [COORD_W+1:0] err_t;

    typedef struct packed {
        coord_t              x;
        coord_t              y;
        logic [ADDR_W-1:0]   addr;
        logic [COLOUR_W-1:0] colour;
        logic                vis;
        logic                last;
    } pixel_t;

    // Walks the line exactly as the hardware should and queues its pixels.
    class line_pixel_model_t;
        logic [ADDR_W-1:0]          base_address;
        logic [SIZE_W-1:0]          screen_width;
        logic [SIZE_W-1:0]          screen_height;
        logic [STRIDE_W-1:0]        row_stride;
        logic [BPP_W-1:0]           bytes_per_pixel;
        coord_t                     cur_x;
        coord_t                     cur_y;
        coord_t                     end_x;
        coord_t                     end_y;
        coord_t                     run_x;
        logic signed [COORD_W:0]    rise_neg;
        logic                       x_back;
        logic                       y_back;
        err_t                       err;
        logic [COLOUR_W-1:0]        pen;
        bit                         drawing;
        pixel_t                     pixels_due[$];
        int                         mismatch_count;

        function new();
            base_address    = BASE_ADDRESS_RST;
            screen_width    = SCREEN_WIDTH_RST;
            screen_height   = SCREEN_HEIGHT_RST;
            row_stride      = ROW_STRIDE_RST;
            bytes_per_pixel = BYTES_PER_PIXEL_RST;
            cur_x           = '0;
            cur_y           = '0;
            end_x           = '0;
            end_y           = '0;
            run_x           = '0;
            rise_neg        = '0;
            x_back          = 1'b0;
            y_back          = 1'b0;
            err             = '0;
            pen             = '0;
            drawing         = 1'b0;
            mismatch_count  = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            unique case (index)
                CFG_BASE_ADDRESS:    base_address    = data[ADDR_W-1:0];
                CFG_SCREEN_WIDTH:    screen_width    = data[SIZE_W-1:0];
                CFG_SCREEN_HEIGHT:   screen_height   = data[SIZE_W-1:0];
                CFG_ROW_STRIDE:      row_stride      = data[STRIDE_W-1:0];
                CFG_BYTES_PER_PIXEL: bytes_per_pixel = data[BPP_W-1:0];
                default: ;
            endcase
        endfunction

        // Returns 1 when the transaction loads a line or yields a pixel.
        function bit accept_command(op_t op, coord_t sx, coord_t sy, coord_t fx,
                                    coord_t fy, logic [COLOUR_W-1:0] colour);
            coord_t rise;
            int     doubled;
            pixel_t px;
            if (op == OP_LOAD) begin
                cur_x    = sx;
                cur_y    = sy;
                end_x    = fx;
                end_y    = fy;
                run_x    = (sx > fx) ? sx - fx : fx - sx;
                rise     = (sy > fy) ? sy - fy : fy - sy;
                rise_neg = -$signed({1'b0, rise});
                x_back   = !(sx < fx);
                y_back   = !(sy < fy);
                err      = err_t'(int'(run_x) + int'(rise_neg));
                pen      = colour;
                drawing  = 1'b1;
                return 1'b1;
            end
            if (!drawing)
                return 1'b0;

            px.x      = cur_x;
            px.y      = cur_y;
            px.addr   = base_address + 32'(cur_y) * 32'(row_stride)
                      + 32'(cur_x) * 32'(bytes_per_pixel);
            px.colour = pen;
            px.vis    = (32'(cur_x) < 32'(screen_width)) && (32'(cur_y) < 32'(screen_height));
            px.last   = (cur_x == end_x) && (cur_y == end_y);
            pixels_due.push_back(px);

            // One Bresenham step, both axes judged on the same doubled error.
            if (px.last) begin
                drawing = 1'b0;
            end
            else begin
                doubled = 2 * int'(err);
                if (doubled >= int'(rise_neg)) begin
                    err   = err_t'(int'(err) + int'(rise_neg));
                    cur_x = x_back ? cur_x - 1'b1 : cur_x + 1'b1;
                end
                if (doubled <= int'(run_x)) begin
                    err   = err_t'(int'(err) + int'(run_x));
                    cur_y = y_back ? cur_y - 1'b1 : cur_y + 1'b1;
                end
            end
            return 1'b1;
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatch_count++;
        endtask

        task check_pixel(pixel_t got);
            pixel_t want;
            if (pixels_due.size() == 0) begin
                report($sformatf("pixel (%0d,%0d) arrived with none outstanding",
                                 got.x, got.y));
                return;
            end
            want = pixels_due.pop_front();
            if (got.x !== want.x)
                report($sformatf("pixel_x %0d, wanted %0d", got.x, want.x));
            if (got.y !== want.y)
                report($sformatf("pixel_y %0d, wanted %0d", got.y, want.y));
            if (got.addr !== want.addr)
                report($sformatf("byte_address %h, wanted %h", got.addr, want.addr));
            if (got.colour !== want.colour)
                report($sformatf("pixel_colour %h, wanted %h", got.colour, want.colour));
            if (got.vis !== want.vis)
                report($sformatf("visible %b, wanted %b at (%0d,%0d)",
                                 got.vis, want.vis, want.x, want.y));
            if (got.last !== want.last)
                report($sformatf("last_pixel %b, wanted %b at (%0d,%0d)",
                                 got.last, want.last, want.x, want.y));
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    op_t                    operation;
    coord_t                 start_x;
    coord_t                 start_y;
    coord_t                 finish_x;
    coord_t                 finish_y;
    logic [COLOUR_W-1:0]    colour_word;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    coord_t                 pixel_x;
    coord_t                 pixel_y;
    logic [ADDR_W-1:0]      byte_address;
    logic [COLOUR_W-1:0]    pixel_colour;
    logic                   visible;
    logic                   last_pixel;

    line_pixel_model_t      sb;
    pixel_t                 seen;
    logic                   hold_active;
    int unsigned            send_idle_pct;
    int unsigned            recv_stall_pct;
    int                     loaded_or_drawn;
    int                     cycle_count = 0;

    bresenham_line_rasterizer_top #(
        .COORD_BITS (COORD_W)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .start_x      (start_x),
        .start_y      (start_y),
        .finish_x     (finish_x),
        .finish_y     (finish_y),
        .colour_word  (colour_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .byte_address (byte_address),
        .pixel_colour (pixel_colour),
        .visible      (visible),
        .last_pixel   (last_pixel)
    );

    always #10 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL bresenham_line_rasterizer_top");
            $finish;
        end
    end

    // Pixel receiver: check each accepted pixel, then pick the next stall.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            seen = {pixel_x, pixel_y, byte_address, pixel_colour, visible, last_pixel};
            sb.check_pixel(seen);
        end
        out_stall <= hold_active || ($urandom_range(99) < recv_stall_pct);
    end

    // Offer one transaction, with a random gap first, and wait until it is taken.
    task automatic send_item(op_t op, coord_t sx, coord_t sy, coord_t fx, coord_t fy,
                             logic [COLOUR_W-1:0] colour);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        start_x     <= sx;
        start_y     <= sy;
        finish_x    <= fx;
        finish_y    <= fy;
        colour_word <= colour;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (sb.accept_command(op, sx, sy, fx, fy, colour))
            loaded_or_drawn++;
    endtask

    task automatic advance_n(int count);
        repeat (count)
            send_item(OP_ADVANCE, coord_t'($urandom()), coord_t'($urandom()),
                      coord_t'($urandom()), coord_t'($urandom()), $urandom());
    endtask

    // Stop offering, let every outstanding pixel drain, then settle.
    task automatic drain_pixels();
        in_valid <= 1'b0;
        while (sb.pixels_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= index;
        cfg_data     <= data;
        @(posedge clk);
        sb.write_register(index, data);
    endtask

    task automatic configure(logic [31:0] base, int w, int h, int stride, int bpp);
        write_cfg(CFG_BASE_ADDRESS, base);
        write_cfg(CFG_SCREEN_WIDTH, w);
        write_cfg(CFG_SCREEN_HEIGHT, h);
        write_cfg(CFG_ROW_STRIDE, stride);
        write_cfg(CFG_BYTES_PER_PIXEL, bpp);
        cfg_write_en <= 1'b0;
    endtask

    // Full-range coordinate, biased toward the two ends of the field.
    function automatic coord_t pick_coord();
        unique case ($urandom_range(9))
            0: return '0;
            1: return coord_t'(COORD_MAX);
            default: return coord_t'($urandom_range(COORD_MAX));
        endcase
    endfunction

    function automatic coord_t coord_near(coord_t c);
        int v;
        v = int'(c) + int'($urandom_range(48)) - 24;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return coord_t'(v);
    endfunction

    // Mostly complete short lines with random content; some long lines cut
    // short, some abandoned midway, and some stray transactions.
    task automatic draw_random_lines(int target);
        int     kind;
        int     len;
        int     count;
        int     adx;
        int     ady;
        coord_t sx;
        coord_t sy;
        coord_t fx;
        coord_t fy;
        while (loaded_or_drawn < target) begin
            kind = $urandom_range(99);
            if (kind < 8) begin
                send_item(op_t'($urandom_range(1)), pick_coord(), pick_coord(),
                          pick_coord(), pick_coord(), $urandom());
            end
            else begin
                sx = pick_coord();
                sy = pick_coord();
                if (kind < 16) begin
                    fx = pick_coord();
                    fy = pick_coord();
                end
                else begin
                    fx = coord_near(sx);
                    fy = coord_near(sy);
                end
                adx = (sx > fx) ? int'(sx - fx) : int'(fx - sx);
                ady = (sy > fy) ? int'(sy - fy) : int'(fy - sy);
                len = ((adx > ady) ? adx : ady) + 1;
                if (len > 48)
                    count = $urandom_range(48, 1);
                else if (kind < 26)
                    count = $urandom_range(len - 1);
                else
                    count = len + $urandom_range(2);
                send_item(OP_LOAD, sx, sy, fx, fy, $urandom());
                advance_n(count);
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        int phase;
        sb             = new();
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_index      = CFG_BASE_ADDRESS;
        cfg_data       = '0;
        in_valid       = 1'b0;
        operation      = OP_LOAD;
        start_x        = '0;
        start_y        = '0;
        finish_x       = '0;
        finish_y       = '0;
        colour_word    = '0;
        hold_active    = 1'b0;
        send_idle_pct  = 8;
        recv_stall_pct = 76;
        loaded_or_drawn = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines under the reset configuration.
        advance_n(1);                                            // idle advance
        send_item(OP_LOAD, 12'd5, 12'd5, 12'd5, 12'd5, 32'hFFFF_FFFF);
        advance_n(1);                                            // single point
        send_item(OP_LOAD, 12'd4095, 12'd4095, 12'd4092, 12'd4093, 32'h0000_0000);
        advance_n(4);
        send_item(OP_LOAD, 12'd1021, 12'd3, 12'd1025, 12'd3, 32'h1234_5678);
        advance_n(5);                                            // horizontal across width
        send_item(OP_LOAD, 12'd0, 12'd769, 12'd0, 12'd766, 32'hA5A5_5A5A);
        advance_n(4);                                            // vertical across height
        send_item(OP_LOAD, 12'd0, 12'd0, 12'd4095, 12'd4095, 32'hC3C3_3C3C);
        advance_n(2);
        send_item(OP_LOAD, 12'd10, 12'd10, 12'd8, 12'd11, 32'h0F0F_F0F0);  // abandons
        advance_n(4);                                            // last one is dropped
        drain_pixels();

        // Random phases, each with its own register setting; the idle pattern changes every two phases.
        for (phase = 0; phase < 6; phase++) begin
            unique case (phase)
                0: configure(32'hFFFF_FFFF, 4096, 4096, 65535, 4);
                1: configure(32'h0000_0000, 0, 0, 0, 1);
                2: configure($urandom(), $urandom_range(4096), $urandom_range(4096),
                             $urandom_range(65535), 0);
                3: configure($urandom(), $urandom_range(4096), $urandom_range(4096),
                             $urandom_range(65535), 7);
                default: configure($urandom(), $urandom_range(4096), $urandom_range(4096),
                                   $urandom_range(65535), $urandom_range(4, 1));
            endcase
            if (phase < 2) begin
                send_idle_pct  = 8;
                recv_stall_pct = 76;
            end
            else if (phase < 4) begin
                send_idle_pct  = 76;
                recv_stall_pct = 8;
            end
            else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end

            // Long receiver hold while the sender keeps pushing advances.
            if (phase == 4) begin
                fork
                    begin
                        hold_active <= 1'b1;
                        repeat (300) @(posedge clk);
                        hold_active <= 1'b0;
                    end
                join_none
            end

            loaded_or_drawn = 0;
            draw_random_lines(155);
            drain_pixels();
        end

        repeat (8) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.pixels_due.size() == 0)
            $display("PASS bresenham_line_rasterizer_top");
        else
            $display("FAIL bresenham_line_rasterizer_top");
        $finish;
    end

endmodule
